FILE: hdl/btcp_pkg.sv
// Package with the shared types, codes and character constants of the blink time command parser.
`timescale 1ns / 1ps

package btcp_pkg;

  localparam int LINE_MAX = 64;
  localparam int LEN_W    = 7;
  localparam int VAL_W    = 24;
  localparam int STAT_W   = 3;
  localparam int PHASE_W  = 3;
  localparam int POS_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int OUT_W    = 80;

  localparam logic [VAL_W-1:0] VALUE_MAX  = 24'hFF_FFFF;
  localparam logic [VAL_W-1:0] TIME_RESET = 24'd250;

  localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_M    = 8'h6D;
  localparam logic [BYTE_W-1:0] CHAR_S    = 8'h73;
  localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

  // parser phases
  localparam logic [PHASE_W-1:0] PH_PREFIX  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DIGITS  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_GOT_M   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_DONE    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_BAD     = 3'd4;
  localparam logic [PHASE_W-1:0] PH_UNKNOWN = 3'd5;
  localparam logic [PHASE_W-1:0] PH_TOOLONG = 3'd6;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ON_SET  = 3'd0;
  localparam logic [STAT_W-1:0] ST_OFF_SET = 3'd1;
  localparam logic [STAT_W-1:0] ST_ON_BAD  = 3'd2;
  localparam logic [STAT_W-1:0] ST_OFF_BAD = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd4;

  // last prefix character positions and prefix lengths
  localparam logic [POS_W-1:0] ON_LAST  = 3'd5;
  localparam logic [POS_W-1:0] OFF_LAST = 3'd6;
  localparam logic [POS_W-1:0] ON_LEN   = 3'd6;
  localparam logic [POS_W-1:0] OFF_LEN  = 3'd7;

  typedef struct packed {
    logic [VAL_W-1:0]  off_time_ms;
    logic [VAL_W-1:0]  on_time_ms;
    logic [VAL_W-1:0]  parsed_value;
    logic [STAT_W-1:0] status;
  } result_t;

  // "ledon="
  function automatic logic [BYTE_W-1:0] on_char(input logic [POS_W-1:0] p);
    logic [BYTE_W-1:0] c;
    case (p)
      3'd0:    c = 8'h6C;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h64;
      3'd3:    c = 8'h6F;
      3'd4:    c = 8'h6E;
      3'd5:    c = 8'h3D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "ledoff="
  function automatic logic [BYTE_W-1:0] off_char(input logic [POS_W-1:0] p);
    logic [BYTE_W-1:0] c;
    case (p)
      3'd0:    c = 8'h6C;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h64;
      3'd3:    c = 8'h6F;
      3'd4:    c = 8'h66;
      3'd5:    c = 8'h66;
      3'd6:    c = 8'h3D;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/btcp_parser.sv
// Line parser: per-byte state update and status result at each carriage return.
`timescale 1ns / 1ps

module btcp_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          byte_valid_i,
  input  logic [btcp_pkg::BYTE_W-1:0]   byte_i,
  output logic                          res_valid_o,
  output btcp_pkg::result_t             res_o
);
  import btcp_pkg::*;

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               kind_q, kind_d;
  logic               on_pos_q, on_pos_d;
  logic               off_pos_q, off_pos_d;
  logic [VAL_W-1:0]   acc_q, acc_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [VAL_W-1:0]   on_time_q, on_time_d;
  logic [VAL_W-1:0]   off_time_q, off_time_d;

  logic               on_match, off_match, is_digit;
  logic [VAL_W+3:0]   acc_next;
  logic [BYTE_W-1:0]  digit;

  assign on_match  = on_pos_q && (pos_q < ON_LEN) && (byte_i == on_char(pos_q));
  assign off_match = off_pos_q && (pos_q < OFF_LEN) && (byte_i == off_char(pos_q));
  assign is_digit  = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign digit     = byte_i - CHAR_ZERO;
  // acc * 10 + digit, at most 28 bits
  assign acc_next  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                   + {{(VAL_W+4-BYTE_W){1'b0}}, digit};

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    kind_d      = kind_q;
    on_pos_d    = on_pos_q;
    off_pos_d   = off_pos_q;
    acc_d       = acc_q;
    len_d       = len_q;
    on_time_d   = on_time_q;
    off_time_d  = off_time_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (byte_valid_i) begin
      if (byte_i != CHAR_CR) begin
        if (len_q >= LEN_W'(LINE_MAX - 1)) begin
          phase_d = PH_TOOLONG;
        end else begin
          len_d = len_q + 1'b1;
          unique case (phase_q)
            PH_PREFIX: begin
              on_pos_d  = on_match;
              off_pos_d = off_match;
              if (on_match && pos_q == ON_LAST) begin
                kind_d  = 1'b0;
                phase_d = PH_DIGITS;
              end else if (off_match && pos_q == OFF_LAST) begin
                kind_d  = 1'b1;
                phase_d = PH_DIGITS;
              end else if (!on_match && !off_match) begin
                phase_d = PH_UNKNOWN;
              end
              if (pos_q < OFF_LEN) begin
                pos_d = pos_q + 1'b1;
              end
            end
            PH_DIGITS: begin
              if (is_digit) begin
                acc_d = (acc_next > {4'b0000, VALUE_MAX}) ? VALUE_MAX : acc_next[VAL_W-1:0];
              end else if (byte_i == CHAR_M) begin
                phase_d = PH_GOT_M;
              end else begin
                phase_d = PH_BAD;
              end
            end
            PH_GOT_M: begin
              phase_d = (byte_i == CHAR_S) ? PH_DONE : PH_BAD;
            end
            default: begin
            end
          endcase
        end
      end else begin
        res_valid_o = 1'b1;
        if (phase_q == PH_PREFIX || phase_q == PH_UNKNOWN || phase_q == PH_TOOLONG) begin
          res_o.status       = ST_UNKNOWN;
          res_o.parsed_value = '0;
        end else begin
          res_o.parsed_value = acc_q;
          if (phase_q == PH_DONE && acc_q != '0) begin
            if (kind_q) begin
              off_time_d   = acc_q;
              res_o.status = ST_OFF_SET;
            end else begin
              on_time_d    = acc_q;
              res_o.status = ST_ON_SET;
            end
          end else begin
            res_o.status = kind_q ? ST_OFF_BAD : ST_ON_BAD;
          end
        end
        res_o.on_time_ms  = on_time_d;
        res_o.off_time_ms = off_time_d;
        // back to line start
        phase_d   = PH_PREFIX;
        pos_d     = '0;
        kind_d    = 1'b0;
        on_pos_d  = 1'b1;
        off_pos_d = 1'b1;
        acc_d     = '0;
        len_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_PREFIX;
      pos_q      <= '0;
      kind_q     <= 1'b0;
      on_pos_q   <= 1'b1;
      off_pos_q  <= 1'b1;
      acc_q      <= '0;
      len_q      <= '0;
      on_time_q  <= TIME_RESET;
      off_time_q <= TIME_RESET;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      kind_q     <= kind_d;
      on_pos_q   <= on_pos_d;
      off_pos_q  <= off_pos_d;
      acc_q      <= acc_d;
      len_q      <= len_d;
      on_time_q  <= on_time_d;
      off_time_q <= off_time_d;
    end
  end

endmodule

FILE: hdl/btcp_out_stage.sv
// Result register on the master side; refills in the cycle it is drained.
`timescale 1ns / 1ps

module btcp_out_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  btcp_pkg::result_t           res_i,
  input  logic                        ready_i,
  output logic                        valid_o,
  output logic                        space_o,
  output btcp_pkg::result_t           res_o
);
  import btcp_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q, res_d;

  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = res_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

FILE: hdl/blink_time_command_parser_unit.sv
// Top level of the blink time command parser: stream ports, parser and result register.
`timescale 1ns / 1ps

// Takes one received byte per cycle and parses carriage-return-ended lines of the
// form ledon=<n>ms or ledoff=<n>ms. Each carriage return yields one status word
// in the next cycle, carrying the status, the parsed value and both LED times;
// other bytes yield nothing. A byte is taken every cycle unless a status word
// waits unread in the output register while the master side stalls; throughput
// is one byte per cycle, set by the single parse step between the line state
// registers and the output register. Lines of LINE_MAX or more bytes report
// an unknown command. On and off times reset to 250 ms.
module blink_time_command_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata    // [2:0] status, [26:3] parsed_value,
                                      // [50:27] on_time_ms, [74:51] off_time_ms, rest 0
);
  import btcp_pkg::*;

  logic    s_fire, res_valid, space;
  result_t res, res_out;

  assign s_axis_tready = space;
  assign s_fire        = s_axis_tvalid && space;

  btcp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_fire),
    .byte_i       (s_axis_tdata),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  btcp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .space_o (space),
    .res_o   (res_out)
  );

  assign m_axis_tdata = {{(OUT_W - $bits(result_t)){1'b0}}, res_out};

  a_times_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res_out.on_time_ms != '0) && (res_out.off_time_ms != '0))
    else $error("LED time of zero reported");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_out.status == ST_UNKNOWN) |-> (res_out.parsed_value == '0))
    else $error("unknown command with nonzero value");

  a_set_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_out.status == ST_ON_SET)
      |-> (res_out.parsed_value == res_out.on_time_ms))
    else $error("on time does not match value just set");

  a_no_word_on_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tdata != CHAR_CR && !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("status word without carriage return");

endmodule
